/* rtl/core/circle_coverage_contingency_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the circle coverage contingency core
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_COVERAGE_CONTINGENCY_CORE_DEFINES_SVH
`define CIRCLE_COVERAGE_CONTINGENCY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Implication check failed.");
`define CCC_ASSERT_HOLDS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("Invariant check failed.");
`else
`define CCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCC_ASSERT_HOLDS(label, clk, rst_n, expr)
`endif
`endif

/* rtl/core/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types and constants of the circle coverage contingency core.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int COUNT_W      = 21;
  localparam int TALLY_W      = 32;
  localparam int TARGET_W     = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int SCALE        = 10000;
  localparam int UPPER_RESET  = 32767;
  localparam int TARGET_RESET = 5000;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORECAST_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORECAST_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_LOWER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUTH_UPPER    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_TARGET = 3'd7;

  typedef struct packed {
    logic valid;
    logic func;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    logic valid;
    logic func;
  } pass_ctl_t;

  function automatic int max_int(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/core/ccc_cfg.sv */
// ----------------------------------------------------------------------------
// ccc_cfg
// Configuration registers and the registered square of the radius.
// ----------------------------------------------------------------------------
module ccc_cfg #(
  parameter int COORD_BITS = 20,
  parameter int VALUE_BITS = 16,
  localparam int CfgW = ccc_pkg::max_int(ccc_pkg::max_int(COORD_BITS, VALUE_BITS),
                                         ccc_pkg::TARGET_W),
  localparam int RadW = COORD_BITS - 1,
  localparam int SqW  = 2 * RadW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  output logic [COORD_BITS-1:0]         center_x_o,
  output logic [COORD_BITS-1:0]         center_y_o,
  output logic [RadW-1:0]               radius_o,
  output logic [SqW-1:0]                radius_sq_o,
  output logic [VALUE_BITS-1:0]         forecast_lower_o,
  output logic [VALUE_BITS-1:0]         forecast_upper_o,
  output logic [VALUE_BITS-1:0]         truth_lower_o,
  output logic [VALUE_BITS-1:0]         truth_upper_o,
  output logic [ccc_pkg::TARGET_W-1:0]  percent_target_o
);

  localparam logic [VALUE_BITS-1:0] UpperRst = VALUE_BITS'(ccc_pkg::UPPER_RESET);
  localparam logic [ccc_pkg::TARGET_W-1:0] TargetRst =
    ccc_pkg::TARGET_W'(ccc_pkg::TARGET_RESET);

  logic [COORD_BITS-1:0]        center_x_q, center_y_q;
  logic [RadW-1:0]              radius_q;
  logic [SqW-1:0]               radius_sq_q;
  logic [VALUE_BITS-1:0]        f_lo_q, f_hi_q, t_lo_q, t_hi_q;
  logic [ccc_pkg::TARGET_W-1:0] target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      radius_q    <= '0;
      radius_sq_q <= '0;
      f_lo_q      <= '0;
      f_hi_q      <= UpperRst;
      t_lo_q      <= '0;
      t_hi_q      <= UpperRst;
      target_q    <= TargetRst;
    end else begin
      radius_sq_q <= SqW'(radius_q) * SqW'(radius_q);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ccc_pkg::CFG_CENTER_X:       center_x_q <= cfg_data_i[COORD_BITS-1:0];
          ccc_pkg::CFG_CENTER_Y:       center_y_q <= cfg_data_i[COORD_BITS-1:0];
          ccc_pkg::CFG_RADIUS:         radius_q   <= cfg_data_i[RadW-1:0];
          ccc_pkg::CFG_FORECAST_LOWER: f_lo_q     <= cfg_data_i[VALUE_BITS-1:0];
          ccc_pkg::CFG_FORECAST_UPPER: f_hi_q     <= cfg_data_i[VALUE_BITS-1:0];
          ccc_pkg::CFG_TRUTH_LOWER:    t_lo_q     <= cfg_data_i[VALUE_BITS-1:0];
          ccc_pkg::CFG_TRUTH_UPPER:    t_hi_q     <= cfg_data_i[VALUE_BITS-1:0];
          ccc_pkg::CFG_PERCENT_TARGET: target_q   <= cfg_data_i[ccc_pkg::TARGET_W-1:0];
        endcase
      end
    end
  end

  assign center_x_o       = center_x_q;
  assign center_y_o       = center_y_q;
  assign radius_o         = radius_q;
  assign radius_sq_o      = radius_sq_q;
  assign forecast_lower_o = f_lo_q;
  assign forecast_upper_o = f_hi_q;
  assign truth_lower_o    = t_lo_q;
  assign truth_upper_o    = t_hi_q;
  assign percent_target_o = target_q;

endmodule

/* rtl/core/ccc_point_pipe.sv */
// ----------------------------------------------------------------------------
// ccc_point_pipe
// Input register, offset and band stage, and squaring stage for each point.
// ----------------------------------------------------------------------------
module ccc_point_pipe #(
  parameter int COORD_BITS = 20,
  parameter int VALUE_BITS = 16,
  localparam int RadW = COORD_BITS - 1,
  localparam int SqW  = 2 * RadW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [COORD_BITS-1:0]     point_x_i,
  input  logic [COORD_BITS-1:0]     point_y_i,
  input  logic [VALUE_BITS-1:0]     point_value_i,
  input  logic                      last_point_i,
  input  logic [COORD_BITS-1:0]     center_x_i,
  input  logic [COORD_BITS-1:0]     center_y_i,
  input  logic [RadW-1:0]           radius_i,
  input  logic [VALUE_BITS-1:0]     forecast_lower_i,
  input  logic [VALUE_BITS-1:0]     forecast_upper_i,
  input  logic [VALUE_BITS-1:0]     truth_lower_i,
  input  logic [VALUE_BITS-1:0]     truth_upper_i,
  input  logic                      down_ready_i,
  output ccc_pkg::item_ctl_t        ctl_o,
  output logic                      in_box_o,
  output logic                      band_hit_o,
  output logic [SqW-1:0]            dx_sq_o,
  output logic [SqW-1:0]            dy_sq_o
);

  ccc_pkg::item_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic [VALUE_BITS-1:0] s1_val_q;
  logic                  s2_box_q, s2_hit_q, s3_box_q, s3_hit_q;
  logic [RadW-1:0]       s2_dx_q, s2_dy_q;
  logic [SqW-1:0]        s3_dx_sq_q, s3_dy_sq_q;
  logic                  en1, en2, en3;

  logic [COORD_BITS:0]   dx_full, dy_full, dx_abs, dy_abs;
  logic [VALUE_BITS-1:0] lo_c, hi_c;
  logic                  box_c, hit_c;

  assign en3        = !s3_ctl_q.valid || down_ready_i;
  assign en2        = !s2_ctl_q.valid || en3;
  assign en1        = !s1_ctl_q.valid || en2;
  assign in_ready_o = en1;

  always_comb begin
    dx_full = {s1_x_q[COORD_BITS-1], s1_x_q} - {center_x_i[COORD_BITS-1], center_x_i};
    dy_full = {s1_y_q[COORD_BITS-1], s1_y_q} - {center_y_i[COORD_BITS-1], center_y_i};
    dx_abs  = dx_full[COORD_BITS] ? (~dx_full + 1'b1) : dx_full;
    dy_abs  = dy_full[COORD_BITS] ? (~dy_full + 1'b1) : dy_full;
    box_c   = (dx_abs <= {2'b00, radius_i}) && (dy_abs <= {2'b00, radius_i});
    lo_c    = s1_ctl_q.func ? truth_lower_i : forecast_lower_i;
    hi_c    = s1_ctl_q.func ? truth_upper_i : forecast_upper_i;
    hit_c   = ($signed(s1_val_q) >= $signed(lo_c)) && ($signed(s1_val_q) <= $signed(hi_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      if (en1) begin
        s1_ctl_q <= '{valid: in_valid_i, func: func_i, last: last_point_i};
      end
      if (en2) begin
        s2_ctl_q <= s1_ctl_q;
      end
      if (en3) begin
        s3_ctl_q <= s2_ctl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_x_q   <= point_x_i;
      s1_y_q   <= point_y_i;
      s1_val_q <= point_value_i;
    end
    if (en2) begin
      s2_box_q <= box_c;
      s2_hit_q <= hit_c;
      s2_dx_q  <= dx_abs[RadW-1:0];
      s2_dy_q  <= dy_abs[RadW-1:0];
    end
    if (en3) begin
      s3_box_q   <= s2_box_q;
      s3_hit_q   <= s2_hit_q;
      s3_dx_sq_q <= SqW'(s2_dx_q) * SqW'(s2_dx_q);
      s3_dy_sq_q <= SqW'(s2_dy_q) * SqW'(s2_dy_q);
    end
  end

  assign ctl_o      = s3_ctl_q;
  assign in_box_o   = s3_box_q;
  assign band_hit_o = s3_hit_q;
  assign dx_sq_o    = s3_dx_sq_q;
  assign dy_sq_o    = s3_dy_sq_q;

endmodule

/* rtl/core/ccc_accum.sv */
// ----------------------------------------------------------------------------
// ccc_accum
// Circle test, saturating point and hit accumulators, and the pass register.
// ----------------------------------------------------------------------------
module ccc_accum #(
  parameter int COORD_BITS = 20,
  parameter int MAX_POINTS = 1048576,
  localparam int SqW  = 2 * (COORD_BITS - 1),
  localparam int AccW = $clog2(MAX_POINTS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccc_pkg::item_ctl_t  ctl_i,
  input  logic                in_box_i,
  input  logic                band_hit_i,
  input  logic [SqW-1:0]      dx_sq_i,
  input  logic [SqW-1:0]      dy_sq_i,
  input  logic [SqW-1:0]      radius_sq_i,
  output logic                ready_o,
  input  logic                next_ready_i,
  output ccc_pkg::pass_ctl_t  pass_o,
  output logic [AccW-1:0]     hits_o,
  output logic [AccW-1:0]     points_o
);

  localparam logic [AccW-1:0] AccMax = AccW'(MAX_POINTS);

  logic [AccW-1:0]    hits_q, points_q, hits_d, points_d;
  logic [AccW-1:0]    p_hits_q, p_points_q;
  ccc_pkg::pass_ctl_t pass_q;
  logic [SqW:0]       dist_sq;
  logic               in_circle, p_en, take;

  assign dist_sq   = {1'b0, dx_sq_i} + {1'b0, dy_sq_i};
  assign in_circle = in_box_i && (dist_sq <= {1'b0, radius_sq_i});
  assign p_en      = !pass_q.valid || next_ready_i;
  assign ready_o   = !ctl_i.last || p_en;
  assign take      = ctl_i.valid && ready_o;

  always_comb begin
    points_d = points_q;
    hits_d   = hits_q;
    if (in_circle) begin
      points_d = (points_q < AccMax) ? points_q + 1'b1 : AccMax;
      if (band_hit_i) begin
        hits_d = (hits_q < AccMax) ? hits_q + 1'b1 : AccMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      points_q <= '0;
      pass_q   <= '0;
    end else begin
      if (take) begin
        hits_q   <= ctl_i.last ? '0 : hits_d;
        points_q <= ctl_i.last ? '0 : points_d;
      end
      if (p_en) begin
        pass_q <= '{valid: take && ctl_i.last, func: ctl_i.func};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en && take && ctl_i.last) begin
      p_hits_q   <= hits_d;
      p_points_q <= points_d;
    end
  end

  assign pass_o   = pass_q;
  assign hits_o   = p_hits_q;
  assign points_o = p_points_q;

endmodule

/* rtl/core/ccc_score.sv */
// ----------------------------------------------------------------------------
// ccc_score
// Coverage products, coverage decision, contingency tallies, result register.
// ----------------------------------------------------------------------------
module ccc_score #(
  parameter int MAX_POINTS = 1048576,
  localparam int AccW   = $clog2(MAX_POINTS + 1),
  localparam int ProdW  = AccW + ccc_pkg::TARGET_W,
  localparam int CountW = ccc_pkg::COUNT_W,
  localparam int TallyW = ccc_pkg::TALLY_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccc_pkg::pass_ctl_t           pass_i,
  input  logic [AccW-1:0]              hits_i,
  input  logic [AccW-1:0]              points_i,
  input  logic [ccc_pkg::TARGET_W-1:0] percent_target_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         pass_kind_o,
  output logic                         covered_o,
  output logic [CountW-1:0]            hit_count_o,
  output logic [CountW-1:0]            point_count_o,
  output logic [TallyW-1:0]            count_forecast_o,
  output logic [TallyW-1:0]            count_truth_o,
  output logic [TallyW-1:0]            count_success_o,
  output logic [TallyW-1:0]            count_failure_o,
  output logic [TallyW-1:0]            count_false_alarm_o,
  output logic [TallyW-1:0]            count_non_event_o
);

  logic              m_valid_q, m_func_q, m_empty_q, m_tzero_q;
  logic [ProdW-1:0]  m_hprod_q, m_tprod_q;
  logic [AccW-1:0]   m_hits_q, m_points_q;
  logic              out_valid_q, kind_q, covered_q;
  logic [CountW-1:0] hit_cnt_q, pt_cnt_q;
  logic              fc_event_q;
  logic [TallyW-1:0] t_fc_q, t_tr_q, t_succ_q, t_fail_q, t_fa_q, t_non_q;
  logic              en_m, en_out, covered_c, load;

  assign en_out    = !out_valid_q || out_ready_i;
  assign en_m      = !m_valid_q || en_out;
  assign ready_o   = en_m;
  assign load      = en_out && m_valid_q;
  assign covered_c = m_empty_q ? m_tzero_q : (m_hprod_q >= m_tprod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fc_event_q  <= 1'b0;
      t_fc_q      <= '0;
      t_tr_q      <= '0;
      t_succ_q    <= '0;
      t_fail_q    <= '0;
      t_fa_q      <= '0;
      t_non_q     <= '0;
    end else begin
      if (en_m) begin
        m_valid_q <= pass_i.valid;
      end
      if (en_out) begin
        out_valid_q <= m_valid_q;
      end
      if (load) begin
        if (!m_func_q) begin
          fc_event_q <= covered_c;
        end else begin
          if (fc_event_q && t_fc_q != '1) begin
            t_fc_q <= t_fc_q + 1'b1;
          end
          if (covered_c && t_tr_q != '1) begin
            t_tr_q <= t_tr_q + 1'b1;
          end
          priority if (covered_c && fc_event_q) begin
            if (t_succ_q != '1) t_succ_q <= t_succ_q + 1'b1;
          end else if (covered_c) begin
            if (t_fail_q != '1) t_fail_q <= t_fail_q + 1'b1;
          end else if (fc_event_q) begin
            if (t_fa_q != '1) t_fa_q <= t_fa_q + 1'b1;
          end else begin
            if (t_non_q != '1) t_non_q <= t_non_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m && pass_i.valid) begin
      m_func_q   <= pass_i.func;
      m_empty_q  <= (points_i == '0);
      m_tzero_q  <= (percent_target_i == '0);
      m_hprod_q  <= ProdW'(hits_i) * ProdW'(ccc_pkg::SCALE);
      m_tprod_q  <= ProdW'(percent_target_i) * ProdW'(points_i);
      m_hits_q   <= hits_i;
      m_points_q <= points_i;
    end
    if (load) begin
      kind_q    <= m_func_q;
      covered_q <= covered_c;
      hit_cnt_q <= CountW'(m_hits_q);
      pt_cnt_q  <= CountW'(m_points_q);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pass_kind_o         = kind_q;
  assign covered_o           = covered_q;
  assign hit_count_o         = hit_cnt_q;
  assign point_count_o       = pt_cnt_q;
  assign count_forecast_o    = t_fc_q;
  assign count_truth_o       = t_tr_q;
  assign count_success_o     = t_succ_q;
  assign count_failure_o     = t_fail_q;
  assign count_false_alarm_o = t_fa_q;
  assign count_non_event_o   = t_non_q;

endmodule

/* rtl/core/circle_coverage_contingency_core.sv */
// ----------------------------------------------------------------------------
// circle_coverage_contingency_core
// Scores forecast and truth passes over one circular region into a 2x2 table.
// Grid points enter on the input channel, a forecast pass and then a truth
// pass, each closed by a point with last_point_i set. Every pass end yields
// one result transfer; other points yield none.
// The block takes one point per cycle while in_ready_o is high. The result of
// a pass runs from its last point through the input register, the offset
// stage, the squaring stage, the accumulator stage and the coverage product
// stage to the result register.
// Configuration writes are registered; write only while no point is in
// flight. After reset the tallies and accumulators are zero and the
// registers hold their defaults.
// While the receiver stalls, points that close no pass keep flowing into the
// accumulators; in_ready_o drops only when every stage is full.
// ----------------------------------------------------------------------------
`include "circle_coverage_contingency_core_defines.svh"

module circle_coverage_contingency_core #(
  parameter int MAX_POINTS = 1048576,
  parameter int COORD_BITS = 20,
  parameter int VALUE_BITS = 16,
  localparam int CfgW = ccc_pkg::max_int(ccc_pkg::max_int(COORD_BITS, VALUE_BITS),
                                         ccc_pkg::TARGET_W)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CfgW-1:0]               cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [COORD_BITS-1:0]         point_x_i,
  input  logic [COORD_BITS-1:0]         point_y_i,
  input  logic [VALUE_BITS-1:0]         point_value_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pass_kind_o,
  output logic                          covered_o,
  output logic [ccc_pkg::COUNT_W-1:0]   hit_count_o,
  output logic [ccc_pkg::COUNT_W-1:0]   point_count_o,
  output logic [ccc_pkg::TALLY_W-1:0]   count_forecast_o,
  output logic [ccc_pkg::TALLY_W-1:0]   count_truth_o,
  output logic [ccc_pkg::TALLY_W-1:0]   count_success_o,
  output logic [ccc_pkg::TALLY_W-1:0]   count_failure_o,
  output logic [ccc_pkg::TALLY_W-1:0]   count_false_alarm_o,
  output logic [ccc_pkg::TALLY_W-1:0]   count_non_event_o
);

  localparam int RadW = COORD_BITS - 1;
  localparam int SqW  = 2 * RadW;
  localparam int AccW = $clog2(MAX_POINTS + 1);

  logic [COORD_BITS-1:0]        center_x, center_y;
  logic [RadW-1:0]              radius;
  logic [SqW-1:0]               radius_sq, dx_sq, dy_sq;
  logic [VALUE_BITS-1:0]        f_lo, f_hi, t_lo, t_hi;
  logic [ccc_pkg::TARGET_W-1:0] target;
  ccc_pkg::item_ctl_t           pt_ctl;
  ccc_pkg::pass_ctl_t           pass_ctl;
  logic                         in_box, band_hit, acc_ready, score_ready;
  logic [AccW-1:0]              pass_hits, pass_points;

  ccc_cfg #(
    .COORD_BITS(COORD_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .center_x_o       (center_x),
    .center_y_o       (center_y),
    .radius_o         (radius),
    .radius_sq_o      (radius_sq),
    .forecast_lower_o (f_lo),
    .forecast_upper_o (f_hi),
    .truth_lower_o    (t_lo),
    .truth_upper_o    (t_hi),
    .percent_target_o (target)
  );

  ccc_point_pipe #(
    .COORD_BITS(COORD_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_point_pipe (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .point_value_i    (point_value_i),
    .last_point_i     (last_point_i),
    .center_x_i       (center_x),
    .center_y_i       (center_y),
    .radius_i         (radius),
    .forecast_lower_i (f_lo),
    .forecast_upper_i (f_hi),
    .truth_lower_i    (t_lo),
    .truth_upper_i    (t_hi),
    .down_ready_i     (acc_ready),
    .ctl_o            (pt_ctl),
    .in_box_o         (in_box),
    .band_hit_o       (band_hit),
    .dx_sq_o          (dx_sq),
    .dy_sq_o          (dy_sq)
  );

  ccc_accum #(
    .COORD_BITS(COORD_BITS),
    .MAX_POINTS(MAX_POINTS)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pt_ctl),
    .in_box_i     (in_box),
    .band_hit_i   (band_hit),
    .dx_sq_i      (dx_sq),
    .dy_sq_i      (dy_sq),
    .radius_sq_i  (radius_sq),
    .ready_o      (acc_ready),
    .next_ready_i (score_ready),
    .pass_o       (pass_ctl),
    .hits_o       (pass_hits),
    .points_o     (pass_points)
  );

  ccc_score #(
    .MAX_POINTS(MAX_POINTS)
  ) u_score (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pass_i              (pass_ctl),
    .hits_i              (pass_hits),
    .points_i            (pass_points),
    .percent_target_i    (target),
    .ready_o             (score_ready),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pass_kind_o         (pass_kind_o),
    .covered_o           (covered_o),
    .hit_count_o         (hit_count_o),
    .point_count_o       (point_count_o),
    .count_forecast_o    (count_forecast_o),
    .count_truth_o       (count_truth_o),
    .count_success_o     (count_success_o),
    .count_failure_o     (count_failure_o),
    .count_false_alarm_o (count_false_alarm_o),
    .count_non_event_o   (count_non_event_o)
  );

  // Input back-pressure only arises when the result register is stalled.
  `CCC_ASSERT_IMPL(a_ready_low_only_on_stall, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)

  // The truth tally only moves with a truth-pass result.
  `CCC_ASSERT_IMPL(a_truth_tally_on_truth_result, clk_i, rst_ni, count_truth_o != $past(count_truth_o), out_valid_o && pass_kind_o)

  // At most one outcome cell of the table moves at a time.
  `CCC_ASSERT_HOLDS(a_one_outcome, clk_i, rst_ni, $countones({count_success_o != $past(count_success_o), count_failure_o != $past(count_failure_o), count_false_alarm_o != $past(count_false_alarm_o), count_non_event_o != $past(count_non_event_o)}) <= 1)

endmodule

/* tb/sv/circle_coverage_contingency_checker.sv */
// ----------------------------------------------------------------------------
// Circle coverage contingency checker
// Watches the configuration port and both channels of the core. Every point
// transfer is scored against its own copy of the registers, accumulators and
// 2x2 tallies. A pass end queues the expected result, and every result
// transfer is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
package ccc_test_pkg;

  typedef enum logic {
    FORECAST_POINT = 1'b0,
    TRUTH_POINT    = 1'b1
  } point_kind_e;

endpackage

module circle_coverage_contingency_checker
  import ccc_pkg::*;
  import ccc_test_pkg::*;
#(
  parameter int MAX_POINTS = 1048576,
  parameter int COORD_BITS = 20,
  parameter int VALUE_BITS = 16,
  parameter int CFG_W      = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [VALUE_BITS-1:0] point_value_i,
  input  logic                  last_point_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  pass_kind_i,
  input  logic                  covered_i,
  input  logic [COUNT_W-1:0]    hit_count_i,
  input  logic [COUNT_W-1:0]    point_count_i,
  input  logic [TALLY_W-1:0]    count_forecast_i,
  input  logic [TALLY_W-1:0]    count_truth_i,
  input  logic [TALLY_W-1:0]    count_success_i,
  input  logic [TALLY_W-1:0]    count_failure_i,
  input  logic [TALLY_W-1:0]    count_false_alarm_i,
  input  logic [TALLY_W-1:0]    count_non_event_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic               pass_kind;
    logic               covered;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] point_count;
    logic [TALLY_W-1:0] cnt_forecast;
    logic [TALLY_W-1:0] cnt_truth;
    logic [TALLY_W-1:0] cnt_success;
    logic [TALLY_W-1:0] cnt_failure;
    logic [TALLY_W-1:0] cnt_false_alarm;
    logic [TALLY_W-1:0] cnt_non_event;
  } pass_score_t;

  pass_score_t score_q[$];

  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] radius;
  logic signed [VALUE_BITS-1:0] fc_lower;
  logic signed [VALUE_BITS-1:0] fc_upper;
  logic signed [VALUE_BITS-1:0] tr_lower;
  logic signed [VALUE_BITS-1:0] tr_upper;
  logic        [TARGET_W-1:0]   target;

  longint unsigned    hits_run;
  longint unsigned    points_run;
  logic               forecast_hit;
  logic [TALLY_W-1:0] tally_forecast;
  logic [TALLY_W-1:0] tally_truth;
  logic [TALLY_W-1:0] tally_success;
  logic [TALLY_W-1:0] tally_failure;
  logic [TALLY_W-1:0] tally_false_alarm;
  logic [TALLY_W-1:0] tally_non_event;
  int                 mismatches = 0;

  function automatic longint unsigned distance(longint a, longint b);
    longint unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d;
  endfunction

  function automatic bit in_circle(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    longint unsigned r;
    longint unsigned dx;
    longint unsigned dy;
    r  = longint'(radius);
    dx = distance(longint'($signed(px)), longint'(center_x));
    dy = distance(longint'($signed(py)), longint'(center_y));
    if (dx > r || dy > r) begin
      return 1'b0;
    end
    return dx * dx + dy * dy <= r * r;
  endfunction

  function automatic logic [TALLY_W-1:0] bump(logic [TALLY_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic score_point();
    longint      v;
    longint      lo;
    longint      hi;
    bit          cov;
    pass_score_t s;
    v = longint'($signed(point_value_i));
    if (func_i == TRUTH_POINT) begin
      lo = longint'(tr_lower);
      hi = longint'(tr_upper);
    end else begin
      lo = longint'(fc_lower);
      hi = longint'(fc_upper);
    end
    if (in_circle(point_x_i, point_y_i)) begin
      if (points_run < MAX_POINTS) points_run++;
      if (v >= lo && v <= hi && hits_run < MAX_POINTS) hits_run++;
    end
    if (last_point_i) begin
      if (points_run == 0) begin
        cov = (target == 0);
      end else begin
        cov = (hits_run * longint'(SCALE) >= longint'(target) * points_run);
      end
      if (func_i == FORECAST_POINT) begin
        forecast_hit = cov;
      end else begin
        if (forecast_hit) tally_forecast = bump(tally_forecast);
        if (cov) tally_truth = bump(tally_truth);
        if (cov && forecast_hit) begin
          tally_success = bump(tally_success);
        end else if (cov) begin
          tally_failure = bump(tally_failure);
        end else if (forecast_hit) begin
          tally_false_alarm = bump(tally_false_alarm);
        end else begin
          tally_non_event = bump(tally_non_event);
        end
      end
      s.pass_kind       = func_i;
      s.covered         = cov;
      s.hit_count       = hits_run[COUNT_W-1:0];
      s.point_count     = points_run[COUNT_W-1:0];
      s.cnt_forecast    = tally_forecast;
      s.cnt_truth       = tally_truth;
      s.cnt_success     = tally_success;
      s.cnt_failure     = tally_failure;
      s.cnt_false_alarm = tally_false_alarm;
      s.cnt_non_event   = tally_non_event;
      score_q.push_back(s);
      hits_run   = 0;
      points_run = 0;
    end
  endtask

  task automatic check_score();
    pass_score_t e;
    if (score_q.size() == 0) begin
      report_mismatch("result transfer with no pass end pending, pass_kind",
                      64'(pass_kind_i), 64'(0));
    end else begin
      e = score_q.pop_front();
      if (pass_kind_i !== e.pass_kind) begin
        report_mismatch("pass_kind", 64'(pass_kind_i), 64'(e.pass_kind));
      end
      if (covered_i !== e.covered) begin
        report_mismatch("covered", 64'(covered_i), 64'(e.covered));
      end
      if (hit_count_i !== e.hit_count) begin
        report_mismatch("hit_count", 64'(hit_count_i), 64'(e.hit_count));
      end
      if (point_count_i !== e.point_count) begin
        report_mismatch("point_count", 64'(point_count_i), 64'(e.point_count));
      end
      if (count_forecast_i !== e.cnt_forecast) begin
        report_mismatch("count_forecast", 64'(count_forecast_i), 64'(e.cnt_forecast));
      end
      if (count_truth_i !== e.cnt_truth) begin
        report_mismatch("count_truth", 64'(count_truth_i), 64'(e.cnt_truth));
      end
      if (count_success_i !== e.cnt_success) begin
        report_mismatch("count_success", 64'(count_success_i), 64'(e.cnt_success));
      end
      if (count_failure_i !== e.cnt_failure) begin
        report_mismatch("count_failure", 64'(count_failure_i), 64'(e.cnt_failure));
      end
      if (count_false_alarm_i !== e.cnt_false_alarm) begin
        report_mismatch("count_false_alarm", 64'(count_false_alarm_i),
                        64'(e.cnt_false_alarm));
      end
      if (count_non_event_i !== e.cnt_non_event) begin
        report_mismatch("count_non_event", 64'(count_non_event_i), 64'(e.cnt_non_event));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x          = '0;
      center_y          = '0;
      radius            = '0;
      fc_lower          = '0;
      fc_upper          = VALUE_BITS'(UPPER_RESET);
      tr_lower          = '0;
      tr_upper          = VALUE_BITS'(UPPER_RESET);
      target            = TARGET_W'(TARGET_RESET);
      hits_run          = 0;
      points_run        = 0;
      forecast_hit      = 1'b0;
      tally_forecast    = '0;
      tally_truth       = '0;
      tally_success     = '0;
      tally_failure     = '0;
      tally_false_alarm = '0;
      tally_non_event   = '0;
      score_q.delete();
      pending_o        <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CENTER_X:       center_x = cfg_data_i[COORD_BITS-1:0];
          CFG_CENTER_Y:       center_y = cfg_data_i[COORD_BITS-1:0];
          CFG_RADIUS:         radius   = cfg_data_i[COORD_BITS-2:0];
          CFG_FORECAST_LOWER: fc_lower = cfg_data_i[VALUE_BITS-1:0];
          CFG_FORECAST_UPPER: fc_upper = cfg_data_i[VALUE_BITS-1:0];
          CFG_TRUTH_LOWER:    tr_lower = cfg_data_i[VALUE_BITS-1:0];
          CFG_TRUTH_UPPER:    tr_upper = cfg_data_i[VALUE_BITS-1:0];
          CFG_PERCENT_TARGET: target   = cfg_data_i[TARGET_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_score();
      if (in_valid_i && in_ready_i) score_point();
      pending_o        <= score_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

/* tb/sv/circle_coverage_contingency_core_test.sv */
// ----------------------------------------------------------------------------
// Circle coverage contingency core test
// Drives grid points into the core with random gaps and stalls the result
// channel at random. A short directed run covers coordinate and value
// extremes, empty passes, inverted bands, targets of zero, full and above
// full scale, mixed passes and truth passes without a forecast. Random
// phases follow, each under a new register setting, made mostly of
// forecast and truth pass pairs with some noise and unterminated passes.
// A separate checker scores every transfer and reports the mismatches.
// ----------------------------------------------------------------------------
module circle_coverage_contingency_core_test;
  import ccc_pkg::*;
  import ccc_test_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int COORD_BITS   = 20;
  localparam int VALUE_BITS   = 16;
  localparam int CFG_W        = 20;
  localparam int COORD_MIN    = -524288;
  localparam int COORD_MAX    = 524287;
  localparam int VALUE_MIN    = -32768;
  localparam int VALUE_MAX    = 32767;
  localparam int RADIUS_MAX   = 524287;
  localparam int TARGET_MAX   = 16383;
  localparam int GAP_MAX      = 12;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  func;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [VALUE_BITS-1:0] point_value;
  logic                  last_point;
  logic                  out_valid;
  logic                  out_ready;
  logic                  pass_kind;
  logic                  covered;
  logic [COUNT_W-1:0]    hit_count;
  logic [COUNT_W-1:0]    point_count;
  logic [TALLY_W-1:0]    count_forecast;
  logic [TALLY_W-1:0]    count_truth;
  logic [TALLY_W-1:0]    count_success;
  logic [TALLY_W-1:0]    count_failure;
  logic [TALLY_W-1:0]    count_false_alarm;
  logic [TALLY_W-1:0]    count_non_event;
  int                    mismatch_count;
  int                    pending;

  int          cfg_next [8];
  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned points_sent;
  int unsigned cycle_count;
  bit          point_held;
  bit          ready_held;

  circle_coverage_contingency_core i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .func_i             (func),
    .point_x_i          (point_x),
    .point_y_i          (point_y),
    .point_value_i      (point_value),
    .last_point_i       (last_point),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .pass_kind_o        (pass_kind),
    .covered_o          (covered),
    .hit_count_o        (hit_count),
    .point_count_o      (point_count),
    .count_forecast_o   (count_forecast),
    .count_truth_o      (count_truth),
    .count_success_o    (count_success),
    .count_failure_o    (count_failure),
    .count_false_alarm_o(count_false_alarm),
    .count_non_event_o  (count_non_event)
  );

  circle_coverage_contingency_checker #(
    .CFG_W(CFG_W)
  ) i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .func_i             (func),
    .point_x_i          (point_x),
    .point_y_i          (point_y),
    .point_value_i      (point_value),
    .last_point_i       (last_point),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .pass_kind_i        (pass_kind),
    .covered_i          (covered),
    .hit_count_i        (hit_count),
    .point_count_i      (point_count),
    .count_forecast_i   (count_forecast),
    .count_truth_i      (count_truth),
    .count_success_i    (count_success),
    .count_failure_i    (count_failure),
    .count_false_alarm_i(count_false_alarm),
    .count_non_event_i  (count_non_event),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** circle_coverage_contingency_core: FAILED **");
      $finish;
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return int'($urandom_range(0, 1048575)) + COORD_MIN;
    endcase
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      default: return int'($urandom_range(0, 65535)) + VALUE_MIN;
    endcase
  endfunction

  function automatic int near(int c);
    int span;
    int off;
    span = cfg_next[CFG_RADIUS] + cfg_next[CFG_RADIUS] / 4 + 2;
    off  = int'($urandom_range(0, 2 * span)) - span;
    return clamp(c + off, COORD_MIN, COORD_MAX);
  endfunction

  function automatic int pick_value(logic kind);
    int lo;
    int hi;
    lo = (kind == TRUTH_POINT) ? cfg_next[CFG_TRUTH_LOWER] : cfg_next[CFG_FORECAST_LOWER];
    hi = (kind == TRUTH_POINT) ? cfg_next[CFG_TRUTH_UPPER] : cfg_next[CFG_FORECAST_UPPER];
    if (lo <= hi && $urandom_range(0, 3) != 0) begin
      return clamp(lo + int'($urandom_range(0, hi - lo + 4)) - 2, VALUE_MIN, VALUE_MAX);
    end
    return int'($urandom_range(0, 65535)) + VALUE_MIN;
  endfunction

  task automatic load_config();
    cfg_we <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= CFG_W'(cfg_next[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int cx, int cy, int r, int fl, int fu, int tl, int tu, int tgt);
    cfg_next[CFG_CENTER_X]       = cx;
    cfg_next[CFG_CENTER_Y]       = cy;
    cfg_next[CFG_RADIUS]         = r;
    cfg_next[CFG_FORECAST_LOWER] = fl;
    cfg_next[CFG_FORECAST_UPPER] = fu;
    cfg_next[CFG_TRUTH_LOWER]    = tl;
    cfg_next[CFG_TRUTH_UPPER]    = tu;
    cfg_next[CFG_PERCENT_TARGET] = tgt;
    load_config();
  endtask

  task automatic randomize_config();
    int r;
    int fl;
    int fu;
    int tl;
    int tu;
    int tgt;
    int swap;
    case ($urandom_range(0, 7))
      0:       r = 0;
      1:       r = RADIUS_MAX;
      2, 3:    r = $urandom_range(0, RADIUS_MAX);
      default: r = $urandom_range(0, 64);
    endcase
    fl = rand_value();
    fu = rand_value();
    tl = rand_value();
    tu = rand_value();
    if (fl > fu && $urandom_range(0, 4) != 0) begin
      swap = fl;
      fl   = fu;
      fu   = swap;
    end
    if (tl > tu && $urandom_range(0, 4) != 0) begin
      swap = tl;
      tl   = tu;
      tu   = swap;
    end
    case ($urandom_range(0, 9))
      0:       tgt = 0;
      1:       tgt = SCALE;
      2:       tgt = $urandom_range(SCALE + 1, TARGET_MAX);
      default: tgt = $urandom_range(0, SCALE);
    endcase
    set_config(rand_coord(), rand_coord(), r, fl, fu, tl, tu, tgt);
  endtask

  function automatic int unsigned pick_pace();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      default: return GAP_MAX;
    endcase
  endfunction

  task automatic send_point(input logic kind, input int x, input int y, input int v,
                            input logic last);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      if (point_held) in_valid <= 1'b0;
      point_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    point_held  = 1'b1;
    func        <= kind;
    point_x     <= COORD_BITS'(x);
    point_y     <= COORD_BITS'(y);
    point_value <= VALUE_BITS'(v);
    last_point  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
  endtask

  task automatic send_pass(input logic kind);
    int   len;
    bit   open_end;
    logic k;
    len      = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
    open_end = ($urandom_range(0, 15) == 0);
    for (int n = 0; n < len; n++) begin
      k = kind ^ ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_point(k, int'($urandom), int'($urandom), int'($urandom),
                   (n == len - 1) && !open_end);
      end else begin
        send_point(k, near(cfg_next[CFG_CENTER_X]), near(cfg_next[CFG_CENTER_Y]),
                   pick_value(k), (n == len - 1) && !open_end);
      end
    end
  endtask

  // Registers may only change once every point in flight has left the core.
  task automatic drain();
    if (point_held) in_valid <= 1'b0;
    point_held = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned gap;
    out_ready  = 1'b0;
    ready_held = 1'b0;
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_stall_max);
      if (gap > 0) begin
        if (ready_held) out_ready <= 1'b0;
        ready_held = 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (!ready_held) out_ready <= 1'b1;
      ready_held = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned phase_end;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    func          = FORECAST_POINT;
    point_x       = '0;
    point_y       = '0;
    point_value   = '0;
    last_point    = 1'b0;
    point_held    = 1'b0;
    points_sent   = 0;
    in_gap_max    = GAP_MAX;
    out_stall_max = GAP_MAX;
    cfg_next[CFG_CENTER_X]       = 0;
    cfg_next[CFG_CENTER_Y]       = 0;
    cfg_next[CFG_RADIUS]         = 0;
    cfg_next[CFG_FORECAST_LOWER] = 0;
    cfg_next[CFG_FORECAST_UPPER] = UPPER_RESET;
    cfg_next[CFG_TRUTH_LOWER]    = 0;
    cfg_next[CFG_TRUTH_UPPER]    = UPPER_RESET;
    cfg_next[CFG_PERCENT_TARGET] = TARGET_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a truth pass before any forecast, then an empty pass.
    send_point(TRUTH_POINT, 0, 0, 5, 1'b1);
    send_point(FORECAST_POINT, 1, 0, 5, 1'b1);
    drain();

    // Largest radius, full forecast band, inverted truth band, full target.
    set_config(0, 0, RADIUS_MAX, VALUE_MIN, VALUE_MAX, 100, 99, SCALE);
    send_point(FORECAST_POINT, COORD_MAX, 0, VALUE_MIN, 1'b0);
    send_point(FORECAST_POINT, COORD_MIN, 0, 0, 1'b0);
    send_point(FORECAST_POINT, 0, COORD_MIN, 0, 1'b0);
    send_point(FORECAST_POINT, 0, COORD_MAX, VALUE_MAX, 1'b1);
    send_point(TRUTH_POINT, 0, 0, 100, 1'b0);
    send_point(TRUTH_POINT, 5, 5, 99, 1'b1);
    drain();

    // Zero radius in a corner with a zero target.
    set_config(COORD_MIN, COORD_MAX, 0, VALUE_MIN, VALUE_MAX, 100, 99, 0);
    send_point(FORECAST_POINT, 0, 0, 0, 1'b1);
    send_point(TRUTH_POINT, COORD_MIN, COORD_MAX, 0, 1'b1);
    drain();

    // A target above full scale can never be met.
    set_config(COORD_MAX, COORD_MIN, 3, -10, 10, VALUE_MIN, VALUE_MAX, TARGET_MAX);
    send_point(FORECAST_POINT, COORD_MAX, COORD_MIN, 7, 1'b1);
    send_point(TRUTH_POINT, COORD_MAX - 2, COORD_MIN + 2, 0, 1'b1);
    send_point(TRUTH_POINT, COORD_MAX - 3, COORD_MIN + 1, 0, 1'b1);
    drain();

    // A mixed pass, then a forecast event that outlives its truth pass.
    set_config(COORD_MAX, COORD_MIN, 3, -10, 10, VALUE_MIN, VALUE_MAX, TARGET_RESET);
    send_point(FORECAST_POINT, COORD_MAX, COORD_MIN, -10, 1'b0);
    send_point(TRUTH_POINT, COORD_MAX, COORD_MIN, -11, 1'b0);
    send_point(FORECAST_POINT, COORD_MAX - 1, COORD_MIN, 11, 1'b0);
    send_point(TRUTH_POINT, COORD_MAX, COORD_MIN + 3, 10, 1'b1);
    send_point(FORECAST_POINT, COORD_MAX, COORD_MIN, 10, 1'b1);
    send_point(TRUTH_POINT, COORD_MAX, COORD_MIN, 0, 1'b1);
    send_point(TRUTH_POINT, 0, 0, 0, 1'b1);
    drain();

    random_start = points_sent;
    while (points_sent - random_start < RANDOM_ITEMS) begin
      in_gap_max    = pick_pace();
      out_stall_max = pick_pace();
      randomize_config();
      phase_end = points_sent + $urandom_range(60, 150);
      while (points_sent < phase_end) begin
        case ($urandom_range(0, 7))
          0:       send_pass(TRUTH_POINT);
          1:       send_pass(FORECAST_POINT);
          default: begin
            send_pass(FORECAST_POINT);
            send_pass(TRUTH_POINT);
          end
        endcase
      end
      // Close any pass left open so that its points do not cross a setting change.
      send_point(TRUTH_POINT, near(cfg_next[CFG_CENTER_X]), near(cfg_next[CFG_CENTER_Y]),
                 pick_value(TRUTH_POINT), 1'b1);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("** circle_coverage_contingency_core: PASSED **");
    end else begin
      $display("** circle_coverage_contingency_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ccc_pkg.sv
rtl/core/ccc_cfg.sv
rtl/core/ccc_point_pipe.sv
rtl/core/ccc_accum.sv
rtl/core/ccc_score.sv
rtl/core/circle_coverage_contingency_core.sv
tb/sv/circle_coverage_contingency_checker.sv
tb/sv/circle_coverage_contingency_core_test.sv
